// ===== design/rkc_pkg.sv =====
// rkc_pkg: types, constants and register codes for the RGB 3x3 convolution block.
// No dependencies; imported by every module of the block except rkc_ram.
`timescale 1ns / 1ps
package rkc_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int COL_W     = $clog2(MAX_WIDTH + 1);
   localparam int W_W       = 11;
   localparam int H_W       = 12;
   localparam int ROW_W     = H_W + 1;
   localparam int DIV_W     = 12;
   localparam int OFF_W     = 9;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;
   localparam int PIX_W     = 24;
   localparam int ACC_W     = 20;
   localparam int NUM_W     = 22;
   localparam int OFFD_W    = OFF_W + DIV_W + 1;
   localparam int DIV_STEPS = 21;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_TOP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MID   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_BOT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_DIVISOR  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_OFFSET   = 3'd6;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       commit;
      logic       mac_clear;
      logic       mac_en;
      logic [1:0] tap_row;
      logic [1:0] tap_col;
      logic       div_load;
      logic       div_en;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic no_work;
      logic edge_only;
      logic has_result;
      logic out_busy;
   } stat_type;

endpackage

// ===== design/rkc_ram.sv =====
// rkc_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module rkc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/rkc_div.sv =====
// rkc_div: restoring divider, one quotient bit per cycle while step is high, result saturated to 0..255.
// Depends on rkc_pkg.
`timescale 1ns / 1ps
module rkc_div (
   input  logic                              clock,
   input  logic                              load,
   input  logic                              step,
   input  logic signed [rkc_pkg::NUM_W-1:0]  num,
   input  logic [rkc_pkg::DIV_W-1:0]         den,
   output logic [7:0]                        quotient
);
   import rkc_pkg::*;

   logic                 neg_ff, neg_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_STEPS-1]};
   assign fits  = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   always_comb begin
      neg_in = neg_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (load) begin
         neg_in = num[NUM_W-1];
         rem_in = '0;
         quo_in = num[DIV_STEPS-1:0];
      end else if (step) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_STEPS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // negative quotient truncates to zero or below: clamps to zero
   assign quotient = neg_ff ? 8'd0 : ((|quo_ff[DIV_STEPS-1:8]) ? 8'd255 : quo_ff[7:0]);
endmodule

// ===== design/rkc_datapath.sv =====
// rkc_datapath: config registers, position counters, line stores, window, MAC and dividers.
// Depends on rkc_pkg, rkc_ram, rkc_div.
`timescale 1ns / 1ps
module rkc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rkc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rkc_pkg::CSR_W-1:0]         csr_wdata,
   input  rkc_pkg::req_type                  req_data,
   input  rkc_pkg::cmd_type                  cmd,
   output rkc_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rkc_pkg::rsp_type                  rsp_data
);
   import rkc_pkg::*;

   // configuration
   logic [W_W-1:0]          width_ff;
   logic [H_W-1:0]          height_ff;
   logic [CSR_W-1:0]        krow_ff [3];
   logic [DIV_W-1:0]        divisor_ff;
   logic signed [OFF_W-1:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= W_W'(MAX_WIDTH);
         height_ff  <= H_W'(1);
         krow_ff[0] <= '0;
         krow_ff[1] <= CSR_W'(65536);
         krow_ff[2] <= '0;
         divisor_ff <= DIV_W'(1);
         offset_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[W_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[H_W-1:0];
            CSR_KERNEL_TOP:   krow_ff[0] <= csr_wdata;
            CSR_KERNEL_MID:   krow_ff[1] <= csr_wdata;
            CSR_KERNEL_BOT:   krow_ff[2] <= csr_wdata;
            CSR_SUM_DIVISOR:  divisor_ff <= csr_wdata[DIV_W-1:0];
            CSR_SUM_OFFSET:   offset_ff  <= csr_wdata[OFF_W-1:0];
            default: ;
         endcase
      end
   end

   logic [COL_W-1:0] w_eff;
   logic [H_W-1:0]   h_eff;
   logic [ROW_W-1:0] h_ext, h_plus1;
   logic [DIV_W-1:0] d_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = COL_W'(1);
      end else if (COL_W'(width_ff) > COL_W'(MAX_WIDTH)) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(width_ff);
      end
   end
   assign h_eff   = (height_ff == '0) ? H_W'(1) : height_ff;
   assign h_ext   = {1'b0, h_eff};
   assign h_plus1 = h_ext + ROW_W'(1);
   assign d_eff   = (divisor_ff == '0) ? DIV_W'(1) : divisor_ff;

   // input position and step decode
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             wrap, restart;
   logic [COL_W-1:0] col_a, x;
   logic [ROW_W-1:0] row_a, row;
   logic             no_work, edge_only, edge_c, emit_c;

   assign wrap    = col_ff >= w_eff;
   assign col_a   = wrap ? '0 : col_ff;
   assign row_a   = wrap ? row_ff + ROW_W'(1) : row_ff;
   assign restart = row_a > h_plus1;
   assign x       = restart ? '0 : col_a;
   assign row     = restart ? '0 : row_a;

   assign no_work   = (row < h_ext) && (req_data.opcode == OP_DRAIN);
   assign edge_only = !no_work && (row == h_plus1);
   assign edge_c    = (x == '0) && (row >= ROW_W'(2));
   assign emit_c    = (x != '0) && (row >= ROW_W'(1));

   assign stat.no_work    = no_work;
   assign stat.edge_only  = edge_only;
   assign stat.has_result = edge_only || (!no_work && (edge_c || emit_c));
   assign stat.out_busy   = rsp_valid && !rsp_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.accept) begin
         if (no_work) begin
            col_in = x;
            row_in = row;
         end else if (edge_only) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = x + COL_W'(1);
            row_in = row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // captured request
   logic [ADDR_W-1:0] x_ff;
   logic [PIX_W-1:0]  pix_ff;
   logic              wr_ok_ff, top_dup_ff, bot_dup_ff, fe_ff;
   logic [1:0]        cols_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff       <= x[ADDR_W-1:0];
         pix_ff     <= {req_data.blue_in, req_data.green_in, req_data.red_in};
         wr_ok_ff   <= row < h_ext;
         top_dup_ff <= row == ROW_W'(1);
         bot_dup_ff <= row == h_ext;
         fe_ff      <= edge_only;
         if (edge_only) begin
            cols_ff[0] <= (w_eff == COL_W'(1)) ? 2'd2 : 2'd1;
            cols_ff[1] <= 2'd2;
            cols_ff[2] <= 2'd2;
         end else if (edge_c) begin
            // right edge after the shift: old columns move one left
            cols_ff[0] <= (w_eff == COL_W'(1)) ? 2'd1 : 2'd0;
            cols_ff[1] <= 2'd1;
            cols_ff[2] <= 2'd1;
         end else begin
            cols_ff[0] <= (x == COL_W'(1)) ? 2'd1 : 2'd0;
            cols_ff[1] <= 2'd1;
            cols_ff[2] <= 2'd2;
         end
      end
   end

   // line stores
   logic [PIX_W-1:0] upper_rd, lower_rd;

   rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_ok_ff),
      .wr_addr (x_ff),
      .wr_data (lower_rd),
      .rd_en   (cmd.accept),
      .rd_addr (x[ADDR_W-1:0]),
      .rd_data (upper_rd)
   );

   rkc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_ok_ff),
      .wr_addr (x_ff),
      .wr_data (pix_ff),
      .rd_en   (cmd.accept),
      .rd_addr (x[ADDR_W-1:0]),
      .rd_data (lower_rd)
   );

   // 3x3 window, column 2 newest
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] top_px, bot_px;

   assign top_px = top_dup_ff ? lower_rd : upper_rd;
   assign bot_px = bot_dup_ff ? lower_rd : pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.commit) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= top_px;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= lower_rd;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= bot_px;
      end
   end

   // one tap per cycle, three channels in parallel
   logic [3:0]              win_idx;
   logic [PIX_W-1:0]        tap_px;
   logic signed [7:0]       coef;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic signed [16:0]      prod [3];

   assign win_idx = {cmd.tap_row, 1'b0} + {2'b00, cmd.tap_row}
                  + {2'b00, cols_ff[cmd.tap_col]};
   assign tap_px  = win_ff[win_idx];
   assign coef    = krow_ff[cmd.tap_row][{cmd.tap_col, 3'b000} +: 8];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = coef * $signed({1'b0, tap_px[8*ch +: 8]});
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         if (cmd.mac_clear) begin
            acc_ff[ch] <= '0;
         end else if (cmd.mac_en) begin
            acc_ff[ch] <= acc_ff[ch] + ACC_W'(prod[ch]);
         end
      end
   end

   // offset scaled by divisor, kept current from the config registers
   logic signed [OFFD_W-1:0] offd_ff;

   always_ff @(posedge clock) begin
      offd_ff <= offset_ff * $signed({1'b0, d_eff});
   end

   logic [7:0] quo [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_div
      logic signed [NUM_W-1:0] num;
      assign num = NUM_W'(acc_ff[ch]) + NUM_W'(offd_ff);
      rkc_div u_div (
         .clock    (clock),
         .load     (cmd.div_load),
         .step     (cmd.div_en),
         .num      (num),
         .den      (d_eff),
         .quotient (quo[ch])
      );
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.red_out   <= quo[0];
         rsp_data_ff.green_out <= quo[1];
         rsp_data_ff.blue_out  <= quo[2];
         rsp_data_ff.frame_end <= fe_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// ===== design/rkc_ctrl.sv =====
// rkc_ctrl: sequencer for one request: line store access, nine MAC taps, divide, output.
// Depends on rkc_pkg.
`timescale 1ns / 1ps
module rkc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rkc_pkg::stat_type stat,
   output rkc_pkg::cmd_type  cmd
);
   import rkc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WRITE = 6'b000010,
      ST_MAC   = 6'b000100,
      ST_DIVLD = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        tr_ff, tr_in, tc_ff, tc_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      tr_in    = tr_ff;
      tc_in    = tc_ff;
      step_in  = step_ff;
      res_in   = res_ff;
      cmd      = '0;
      cmd.tap_row = tr_ff;
      cmd.tap_col = tc_ff;
      req_ready = state_ff == ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               res_in     = stat.has_result;
               if (stat.no_work) begin
                  state_in = ST_IDLE;
               end else if (stat.edge_only) begin
                  cmd.mac_clear = 1'b1;
                  tr_in    = '0;
                  tc_in    = '0;
                  state_in = ST_MAC;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            if (res_ff) begin
               cmd.mac_clear = 1'b1;
               tr_in    = '0;
               tc_in    = '0;
               state_in = ST_MAC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (tc_ff == 2'd2) begin
               tc_in = '0;
               tr_in = tr_ff + 2'd1;
               if (tr_ff == 2'd2) begin
                  tr_in    = '0;
                  state_in = ST_DIVLD;
               end
            end else begin
               tc_in = tc_ff + 2'd1;
            end
         end
         ST_DIVLD: begin
            cmd.div_load = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            step_in    = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tr_ff    <= '0;
         tc_ff    <= '0;
         step_ff  <= '0;
         res_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         tr_ff    <= tr_in;
         tc_ff    <= tc_in;
         step_ff  <= step_in;
         res_ff   <= res_in;
      end
   end
endmodule

// ===== design/rgb_kernel_convolution_top.sv =====
// rgb_kernel_convolution_top: streaming 3x3 RGB correlation filter with edge clamping.
// Depends on rkc_pkg, rkc_ctrl, rkc_datapath (rkc_ram, rkc_div).
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_data  (opcode, red/green/blue_in)
//   rsp       out        rsp_valid/rsp_ready  rsp_data  (red/green/blue_out, frame_end)
//   csr       in         csr_wr_en            csr_index, csr_wdata (no read-back)
//
// A request that makes no result (drain inside the image) is taken in the idle state alone;
// a plain pixel without result also passes the write state, which shifts the window. A
// request with a result goes through accept with line store read, window shift, the MAC
// steps (one kernel tap a cycle), divider load, the steps of the bit-serial divider, which
// sets the rate, and the output register load. The final drain tick skips the window shift.
// Synchronous active-high reset clears counters, window and config; line stores are not
// cleared. A stalled rsp holds its register; the next request is taken meanwhile and waits
// at the end only if the output register is still full.
`timescale 1ns / 1ps
module rgb_kernel_convolution_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rkc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rkc_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [rkc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rkc_pkg::CSR_W-1:0]     csr_wdata
);
   import rkc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one request in flight
   rkc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, arithmetic and output register
   rkc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && !rsp_ready))
      else $error("output register overwritten");

   // divider loads only right after the last MAC tap
   a_div_after_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> $past(cmd.mac_en))
      else $error("divider loaded without MAC");

   // a request with work blocks the input on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !stat.no_work) |=> !req_ready)
      else $error("request taken while busy");
`endif
endmodule
